// ===== sv/svprm_pkg.sv =====
`default_nettype none

package svprm_pkg;

  localparam int VOICE_COUNT = 6;
  localparam int PORT_VOICES = 6;
  localparam int VOICE_SPLIT = (VOICE_COUNT + 1) / 2;
  localparam int STAGES      = 5;

  localparam int SAMPLE_W    = 16;
  localparam int PAN_W       = 7;
  localparam int ROUTE_W     = 3;
  localparam int GAIN_W      = 17;
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int FRAC_BITS   = 15;
  localparam int GAIN_DEPTH  = 1 << PAN_W;
  localparam int GainDivisor = GAIN_DEPTH - 1;

  localparam int PAN_REG_W   = VOICE_COUNT * PAN_W;
  localparam int ROUTE_REG_W = VOICE_COUNT * ROUTE_W;
  localparam int CFG_DATA_W  = PAN_REG_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [PAN_REG_W-1:0] PAN_RESET = PAN_REG_W'(64'd2216338399296);
  localparam logic [PAN_W-1:0]     PAN_MAX   = '1;

  localparam int BUS_COUNT = 4;
  localparam int BUS_1L    = 0;
  localparam int BUS_1R    = 1;
  localparam int BUS_2L    = 2;
  localparam int BUS_2R    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAN   = 2'd0,
    CFG_ROUTE = 2'd1
  } cfg_reg_e;

  typedef enum logic [ROUTE_W-1:0] {
    ROUTE_BUS1_STEREO = 3'd0,
    ROUTE_BUS2_STEREO = 3'd1,
    ROUTE_BUS1_LEFT   = 3'd2,
    ROUTE_BUS1_RIGHT  = 3'd3,
    ROUTE_BUS2_LEFT   = 3'd4,
    ROUTE_BUS2_RIGHT  = 3'd5
  } route_e;

  typedef logic signed [SAMPLE_W-1:0]        sample_t;
  typedef logic [GAIN_W-1:0]                 gain_t;
  typedef logic signed [PROD_W-1:0]          prod_t;
  typedef gain_t                             gain_table_t [GAIN_DEPTH];
  typedef logic [BUS_COUNT-1:0][SAMPLE_W-1:0] bus_vec_t;
  typedef bus_vec_t                          voice_bus_t [VOICE_COUNT];

  function automatic logic [31:0] isqrt64(logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = x;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // sqrt(k/127) in unsigned Q1.15, truncated
  function automatic gain_table_t build_gain_table();
    gain_table_t tbl;
    logic [63:0] scaled;
    logic [31:0] root;
    for (int k = 0; k < GAIN_DEPTH; k++) begin
      scaled = (64'(k) << 30) / 64'(GainDivisor);
      root   = isqrt64(scaled);
      tbl[k] = root[GAIN_W-1:0];
    end
    return tbl;
  endfunction

  localparam gain_table_t GAIN_TABLE = build_gain_table();

  function automatic sample_t sat_add(sample_t a, sample_t b);
    logic signed [SAMPLE_W:0] s;
    sample_t r;
    s = $signed({a[SAMPLE_W-1], a}) + $signed({b[SAMPLE_W-1], b});
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      r = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = s[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // divide by 2^15 rounding toward zero; result always fits the sample width
  function automatic sample_t scale_trunc(prod_t p);
    prod_t adj;
    adj = p[PROD_W-1] ? p + PROD_W'((1 << FRAC_BITS) - 1) : p;
    return adj[FRAC_BITS +: SAMPLE_W];
  endfunction

endpackage

`default_nettype wire

// ===== sv/svprm_in_if.sv =====
`default_nettype none

interface svprm_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [svprm_pkg::SAMPLE_W-1:0] voice_0_sample;
  logic signed [svprm_pkg::SAMPLE_W-1:0] voice_1_sample;
  logic signed [svprm_pkg::SAMPLE_W-1:0] voice_2_sample;
  logic signed [svprm_pkg::SAMPLE_W-1:0] voice_3_sample;
  logic signed [svprm_pkg::SAMPLE_W-1:0] voice_4_sample;
  logic signed [svprm_pkg::SAMPLE_W-1:0] voice_5_sample;
  logic [svprm_pkg::PORT_VOICES-1:0]     voice_present;
  logic                          end_of_block;

  modport source (
    output valid, voice_0_sample, voice_1_sample, voice_2_sample,
           voice_3_sample, voice_4_sample, voice_5_sample, voice_present, end_of_block,
    input  ready
  );

  modport sink (
    input  valid, voice_0_sample, voice_1_sample, voice_2_sample,
           voice_3_sample, voice_4_sample, voice_5_sample, voice_present, end_of_block,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/svprm_out_if.sv =====
`default_nettype none

interface svprm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svprm_pkg::SAMPLE_W-1:0] bus1_left;
  logic signed [svprm_pkg::SAMPLE_W-1:0] bus1_right;
  logic signed [svprm_pkg::SAMPLE_W-1:0] bus2_left;
  logic signed [svprm_pkg::SAMPLE_W-1:0] bus2_right;
  logic                                  block_done;

  modport source (
    output valid, bus1_left, bus1_right, bus2_left, bus2_right, block_done,
    input  ready
  );

  modport sink (
    input  valid, bus1_left, bus1_right, bus2_left, bus2_right, block_done,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/six_voice_pan_router_mixer.sv =====
// Six-voice pan and route mixer.
// frame_i carries one word per audio frame: six signed 16-bit voice samples, a
// presence mask and an end-of-block flag. mix_o returns one word per frame with
// the four saturated bus sums (bus 1 and bus 2, left and right) and block_done.
// Pan (7 bits per voice) and route (3 bits per voice) are written through the
// cfg_we_i / cfg_index_i / cfg_data_i port; the user must write them only while
// no frame is in flight; the block does not enforce it. Throughput: one frame per
// cycle while mix_o does not stall. Each frame passes the five-register pipeline:
// gain lookup, multiply, truncate and route, then two saturating add stages
// (voices 0..2, then 3..5, summed strictly in voice order).
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles collapse when mix_o stalls and frame_i.ready
// drops only once every stage is full; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets every pan to
// centre (64) and every route to bus 1 stereo.

`default_nettype none

module six_voice_pan_router_mixer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [svprm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [svprm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  svprm_in_if.sink                              frame_i,
  svprm_out_if.source                           mix_o
);

  logic [svprm_pkg::PAN_REG_W-1:0]   pan_q;
  logic [svprm_pkg::ROUTE_REG_W-1:0] route_q;

  logic [svprm_pkg::STAGES-1:0] v_q;
  logic [svprm_pkg::STAGES-1:0] en;

  svprm_pkg::sample_t sample_in [svprm_pkg::PORT_VOICES];

  // stage 1: samples and gains
  svprm_pkg::sample_t s1_sample_q [svprm_pkg::VOICE_COUNT];
  svprm_pkg::sample_t s1_sample_d [svprm_pkg::VOICE_COUNT];
  svprm_pkg::gain_t   s1_gl_q     [svprm_pkg::VOICE_COUNT];
  svprm_pkg::gain_t   s1_gl_d     [svprm_pkg::VOICE_COUNT];
  svprm_pkg::gain_t   s1_gr_q     [svprm_pkg::VOICE_COUNT];
  svprm_pkg::gain_t   s1_gr_d     [svprm_pkg::VOICE_COUNT];
  logic [svprm_pkg::VOICE_COUNT-1:0] s1_present_q;
  logic                              s1_eob_q;

  // stage 2: products
  svprm_pkg::sample_t s2_sample_q [svprm_pkg::VOICE_COUNT];
  svprm_pkg::prod_t   s2_pl_q     [svprm_pkg::VOICE_COUNT];
  svprm_pkg::prod_t   s2_pl_d     [svprm_pkg::VOICE_COUNT];
  svprm_pkg::prod_t   s2_pr_q     [svprm_pkg::VOICE_COUNT];
  svprm_pkg::prod_t   s2_pr_d     [svprm_pkg::VOICE_COUNT];
  logic [svprm_pkg::VOICE_COUNT-1:0] s2_present_q;
  logic                              s2_eob_q;

  // stage 3: per-voice bus terms
  svprm_pkg::voice_bus_t s3_term_q;
  svprm_pkg::voice_bus_t s3_term_d;
  logic                  s3_eob_q;

  // stage 4: first partial sums
  svprm_pkg::voice_bus_t s4_term_q;
  svprm_pkg::bus_vec_t   s4_acc_q;
  svprm_pkg::bus_vec_t   s4_acc_d;
  logic                  s4_eob_q;

  // stage 5: final sums, output register
  svprm_pkg::bus_vec_t   s5_acc_q;
  svprm_pkg::bus_vec_t   s5_acc_d;
  logic                  s5_eob_q;

  assign sample_in[0] = frame_i.voice_0_sample;
  assign sample_in[1] = frame_i.voice_1_sample;
  assign sample_in[2] = frame_i.voice_2_sample;
  assign sample_in[3] = frame_i.voice_3_sample;
  assign sample_in[4] = frame_i.voice_4_sample;
  assign sample_in[5] = frame_i.voice_5_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q   <= svprm_pkg::PAN_RESET;
      route_q <= '0;
    end else if (cfg_we_i) begin
      case (svprm_pkg::cfg_reg_e'(cfg_index_i))
        svprm_pkg::CFG_PAN:   pan_q   <= cfg_data_i[svprm_pkg::PAN_REG_W-1:0];
        svprm_pkg::CFG_ROUTE: route_q <= cfg_data_i[svprm_pkg::ROUTE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its successor moves
  always_comb begin
    en[svprm_pkg::STAGES-1] = !v_q[svprm_pkg::STAGES-1] || mix_o.ready;
    for (int k = svprm_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign frame_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= frame_i.valid;
      for (int k = 1; k < svprm_pkg::STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    logic [svprm_pkg::PAN_W-1:0] pan;
    for (int i = 0; i < svprm_pkg::VOICE_COUNT; i++) begin
      pan            = pan_q[svprm_pkg::PAN_W*i +: svprm_pkg::PAN_W];
      s1_sample_d[i] = sample_in[i];
      s1_gl_d[i]     = svprm_pkg::GAIN_TABLE[svprm_pkg::PAN_MAX - pan];
      s1_gr_d[i]     = svprm_pkg::GAIN_TABLE[pan];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sample_q  <= s1_sample_d;
      s1_gl_q      <= s1_gl_d;
      s1_gr_q      <= s1_gr_d;
      s1_present_q <= frame_i.voice_present[svprm_pkg::VOICE_COUNT-1:0];
      s1_eob_q     <= frame_i.end_of_block;
    end
  end

  always_comb begin
    for (int i = 0; i < svprm_pkg::VOICE_COUNT; i++) begin
      s2_pl_d[i] = svprm_pkg::prod_t'(s1_sample_q[i])
                 * svprm_pkg::prod_t'($signed({1'b0, s1_gl_q[i]}));
      s2_pr_d[i] = svprm_pkg::prod_t'(s1_sample_q[i])
                 * svprm_pkg::prod_t'($signed({1'b0, s1_gr_q[i]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_sample_q  <= s1_sample_q;
      s2_pl_q      <= s2_pl_d;
      s2_pr_q      <= s2_pr_d;
      s2_present_q <= s1_present_q;
      s2_eob_q     <= s1_eob_q;
    end
  end

  // stage 3 reads route_q unguarded; user must keep it static while frames fly
  always_comb begin
    logic [svprm_pkg::ROUTE_W-1:0] route;
    for (int i = 0; i < svprm_pkg::VOICE_COUNT; i++) begin
      route        = route_q[svprm_pkg::ROUTE_W*i +: svprm_pkg::ROUTE_W];
      s3_term_d[i] = '0;
      if (s2_present_q[i]) begin
        case (svprm_pkg::route_e'(route))
          svprm_pkg::ROUTE_BUS1_STEREO: begin
            s3_term_d[i][svprm_pkg::BUS_1L] = svprm_pkg::scale_trunc(s2_pl_q[i]);
            s3_term_d[i][svprm_pkg::BUS_1R] = svprm_pkg::scale_trunc(s2_pr_q[i]);
          end
          svprm_pkg::ROUTE_BUS2_STEREO: begin
            s3_term_d[i][svprm_pkg::BUS_2L] = svprm_pkg::scale_trunc(s2_pl_q[i]);
            s3_term_d[i][svprm_pkg::BUS_2R] = svprm_pkg::scale_trunc(s2_pr_q[i]);
          end
          svprm_pkg::ROUTE_BUS1_LEFT:  s3_term_d[i][svprm_pkg::BUS_1L] = s2_sample_q[i];
          svprm_pkg::ROUTE_BUS1_RIGHT: s3_term_d[i][svprm_pkg::BUS_1R] = s2_sample_q[i];
          svprm_pkg::ROUTE_BUS2_LEFT:  s3_term_d[i][svprm_pkg::BUS_2L] = s2_sample_q[i];
          svprm_pkg::ROUTE_BUS2_RIGHT: s3_term_d[i][svprm_pkg::BUS_2R] = s2_sample_q[i];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_term_q <= s3_term_d;
      s3_eob_q  <= s2_eob_q;
    end
  end

  // saturation makes order matter: add strictly voice by voice
  always_comb begin
    s4_acc_d = '0;
    for (int i = 0; i < svprm_pkg::VOICE_SPLIT; i++) begin
      for (int b = 0; b < svprm_pkg::BUS_COUNT; b++) begin
        s4_acc_d[b] = svprm_pkg::sat_add(s4_acc_d[b], s3_term_q[i][b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_term_q <= s3_term_q;
      s4_acc_q  <= s4_acc_d;
      s4_eob_q  <= s3_eob_q;
    end
  end

  always_comb begin
    s5_acc_d = s4_acc_q;
    for (int i = svprm_pkg::VOICE_SPLIT; i < svprm_pkg::VOICE_COUNT; i++) begin
      for (int b = 0; b < svprm_pkg::BUS_COUNT; b++) begin
        s5_acc_d[b] = svprm_pkg::sat_add(s5_acc_d[b], s4_term_q[i][b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_acc_q <= s5_acc_d;
      s5_eob_q <= s4_eob_q;
    end
  end

  assign mix_o.valid      = v_q[svprm_pkg::STAGES-1];
  assign mix_o.bus1_left  = s5_acc_q[svprm_pkg::BUS_1L];
  assign mix_o.bus1_right = s5_acc_q[svprm_pkg::BUS_1R];
  assign mix_o.bus2_left  = s5_acc_q[svprm_pkg::BUS_2L];
  assign mix_o.bus2_right = s5_acc_q[svprm_pkg::BUS_2R];
  assign mix_o.block_done = s5_eob_q;

endmodule

`default_nettype wire

// ===== sv/svprm_checker.sv =====
`default_nettype none

module svprm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [svprm_pkg::SAMPLE_W-1:0] out_b1l_i,
  input wire logic [svprm_pkg::SAMPLE_W-1:0] out_b1r_i,
  input wire logic [svprm_pkg::SAMPLE_W-1:0] out_b2l_i,
  input wire logic [svprm_pkg::SAMPLE_W-1:0] out_b2r_i,
  input wire logic                           out_done_i
);

  // empty pipeline while reset is held
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("mix_o valid during reset");

  // a draining output never blocks the input side
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("frame_i stalled while mix_o is taking words");

  // with the receiver always ready an accepted frame comes out on mix_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && out_ready_i) ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("frame did not reach mix_o in five cycles");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_b1l_i)
      && $stable(out_b1r_i) && $stable(out_b2l_i) && $stable(out_b2r_i)
      && $stable(out_done_i))
    else $error("mix_o word changed while stalled");

endmodule

bind six_voice_pan_router_mixer svprm_checker u_svprm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (frame_i.valid),
  .in_ready_i  (frame_i.ready),
  .out_valid_i (mix_o.valid),
  .out_ready_i (mix_o.ready),
  .out_b1l_i   (mix_o.bus1_left),
  .out_b1r_i   (mix_o.bus1_right),
  .out_b2l_i   (mix_o.bus2_left),
  .out_b2r_i   (mix_o.bus2_right),
  .out_done_i  (mix_o.block_done)
);

`default_nettype wire
